// ----- design/pda_pkg.sv -----
// ----------------------------------------------------------------------------
// PID step package
// Shared widths, register indexes, controller states and the command struct.
// ----------------------------------------------------------------------------
package pda_pkg;

    localparam int DATA_W            = 32;
    localparam int DZ_W              = 31;
    localparam int CNT_W             = 8;
    localparam int IDX_W             = 3;
    localparam int DERIV_SHIFT       = 6;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int DIFF_DIVIDE_DEF   = 4;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_KP   = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI   = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD   = 3'd2;
    localparam logic [IDX_W-1:0] REG_KAW  = 3'd3;
    localparam logic [IDX_W-1:0] REG_KF   = 3'd4;
    localparam logic [IDX_W-1:0] REG_DZ   = 3'd5;
    localparam logic [IDX_W-1:0] REG_OMAX = 3'd6;
    localparam logic [IDX_W-1:0] REG_OMIN = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] kp;
        logic signed [DATA_W-1:0] ki;
        logic signed [DATA_W-1:0] kd;
        logic signed [DATA_W-1:0] kaw;
        logic signed [DATA_W-1:0] kf;
        logic        [DZ_W-1:0]   dz;
        logic signed [DATA_W-1:0] omax;
        logic signed [DATA_W-1:0] omin;
    } t_cfg;

    // One command per datapath step
    typedef struct packed {
        logic load;
        logic restart;
        logic mul_p;
        logic sum;
        logic clamp;
        logic diff;
        logic aw;
        logic integ;
        logic emit;
    } t_cmd;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MULP  = 8'b0000_0010,
        ST_SUM   = 8'b0000_0100,
        ST_CLAMP = 8'b0000_1000,
        ST_DIFF  = 8'b0001_0000,
        ST_AW    = 8'b0010_0000,
        ST_INTEG = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

endpackage

// ----- design/pda_ctrl.sv -----
// ----------------------------------------------------------------------------
// PID step controller
// Sequences the datapath through one step, one item at a time.
// ----------------------------------------------------------------------------
module pda_ctrl
    import pda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_kind,
    input  logic i_slot_free,
    output logic o_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_take;

    // Hold off input items while reset is asserted
    assign o_ready = i_rst_n && (r_state == ST_IDLE);
    assign w_take  = o_ready && i_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_take && !i_kind;
        o_cmd.restart = w_take && i_kind;
        o_cmd.mul_p   = (r_state == ST_MULP);
        o_cmd.sum     = (r_state == ST_SUM);
        o_cmd.clamp   = (r_state == ST_CLAMP);
        o_cmd.diff    = (r_state == ST_DIFF);
        o_cmd.aw      = (r_state == ST_AW);
        o_cmd.integ   = (r_state == ST_INTEG);
        o_cmd.emit    = (r_state == ST_DONE) && i_slot_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && !i_kind) n_state = ST_MULP;
            end
            ST_MULP:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_AW;
            ST_AW:    n_state = ST_INTEG;
            ST_INTEG: n_state = ST_DONE;
            ST_DONE: begin
                if (i_slot_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_kind) |=> (r_state == ST_MULP))
        else $error("compute item did not start the multiply step");

    a_step_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_kind) |-> ##7 (r_state == ST_DONE))
        else $error("compute item did not reach the result stage in seven cycles");

    a_restart_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_kind) |=> (r_state == ST_IDLE))
        else $error("restart item left the controller busy");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && !i_slot_free) |=> (r_state == ST_DONE))
        else $error("result dropped while the output slot was full");
`endif

endmodule

// ----- design/pda_dp.sv -----
// ----------------------------------------------------------------------------
// PID step datapath
// Shared fractional multiplier, loop state and the per-step arithmetic.
// ----------------------------------------------------------------------------
module pda_dp
    import pda_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int DIFF_DIVIDE   = DIFF_DIVIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  t_cfg                     i_cfg,
    input  logic signed [DATA_W-1:0] i_reference,
    input  logic signed [DATA_W-1:0] i_feedback,
    input  logic signed [DATA_W-1:0] i_clamp_error_offset,
    output logic signed [DATA_W-1:0] o_control_out,
    output logic signed [DATA_W-1:0] o_error_value,
    output logic                     o_saturated
);

    // Per-item working registers
    logic signed [DATA_W-1:0]   r_err;
    logic signed [DATA_W-1:0]   r_errdz;
    logic signed [DATA_W-1:0]   r_ofs;
    logic signed [DATA_W-1:0]   r_up;
    logic signed [DATA_W-1:0]   r_sum;
    logic signed [DATA_W-1:0]   r_outv;
    logic                       r_sat;
    logic signed [DATA_W-1:0]   r_saterr;
    logic signed [DATA_W-1:0]   r_ti;
    logic                       r_refresh;
    logic signed [2*DATA_W-1:0] r_prod;

    // Loop state
    logic signed [DATA_W-1:0] r_integ;
    logic signed [DATA_W-1:0] r_deriv;
    logic signed [DATA_W-1:0] r_filt;
    logic signed [DATA_W-1:0] r_prev;
    logic        [CNT_W-1:0]  r_cnt;
    logic                     r_pend;

    logic signed [DATA_W-1:0]   w_err;
    logic signed [DATA_W:0]     w_e33;
    logic signed [DATA_W:0]     w_dz33;
    logic signed [DATA_W:0]     w_pos;
    logic signed [DATA_W:0]     w_neg;
    logic signed [DATA_W-1:0]   w_errdz;
    logic signed [DATA_W-1:0]   w_ma;
    logic signed [DATA_W-1:0]   w_mb;
    logic signed [2*DATA_W-1:0] w_shift;
    logic signed [DATA_W-1:0]   w_frac;
    logic        [CNT_W:0]      w_cnt_inc;
    logic                       w_refresh;
    logic signed [DATA_W-1:0]   w_eff_f;
    logic signed [DATA_W-1:0]   w_eff_p;
    logic signed [DATA_W-1:0]   w_diffsh;
    logic signed [DATA_W-1:0]   n_outv;
    logic                       n_sat;
    logic signed [DATA_W-1:0]   w_isum;
    logic signed [DATA_W-1:0]   n_integ;

    // Error and dead zone
    assign w_err  = i_reference - i_feedback;
    assign w_e33  = {w_err[DATA_W-1], w_err};
    assign w_dz33 = $signed({2'b00, i_cfg.dz});
    assign w_pos  = w_e33 - w_dz33;
    assign w_neg  = w_e33 + w_dz33;

    always_comb begin
        if (!w_err[DATA_W-1] && (w_err != '0)) begin
            w_errdz = w_pos[DATA_W] ? '0 : w_pos[DATA_W-1:0];
        end else if (w_err[DATA_W-1]) begin
            w_errdz = (!w_neg[DATA_W] && (w_neg != '0)) ? '0 : w_neg[DATA_W-1:0];
        end else begin
            w_errdz = '0;
        end
    end

    // Decimation and derivative filter init
    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_refresh = (w_cnt_inc >= (CNT_W+1)'(DIFF_DIVIDE));
    assign w_eff_f   = r_pend ? r_err : r_filt;
    assign w_eff_p   = r_pend ? r_err : r_prev;
    assign w_diffsh  = (w_eff_f - w_eff_p) << DERIV_SHIFT;

    // Shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        priority if (i_cmd.mul_p) begin
            w_ma = i_cfg.kp;
            w_mb = r_errdz;
        end else if (i_cmd.sum) begin
            w_ma = i_cfg.kf;
            w_mb = r_err - r_filt;
        end else if (i_cmd.clamp) begin
            w_ma = i_cfg.ki;
            w_mb = r_up;
        end else if (i_cmd.diff) begin
            w_ma = i_cfg.kd;
            w_mb = w_diffsh;
        end else if (i_cmd.aw) begin
            w_ma = i_cfg.kaw;
            w_mb = r_saterr;
        end else begin
            w_ma = '0;
            w_mb = '0;
        end
    end

    assign w_shift = r_prod >>> FRACTION_BITS;
    assign w_frac  = w_shift[DATA_W-1:0];

    // Output clamp, upper limit checked first
    always_comb begin
        if (r_sum > i_cfg.omax) begin
            n_outv = i_cfg.omax;
            n_sat  = 1'b1;
        end else if (r_sum < i_cfg.omin) begin
            n_outv = i_cfg.omin;
            n_sat  = 1'b1;
        end else begin
            n_outv = r_sum;
            n_sat  = 1'b0;
        end
    end

    // Integrator update with back-calculation or plain clamp
    assign w_isum = r_integ + r_ti + w_frac;

    always_comb begin
        n_integ = (i_cfg.ki == '0) ? '0 : w_isum;
        if (i_cfg.kaw == '0) begin
            if (n_integ > i_cfg.omax) begin
                n_integ = i_cfg.omax;
            end else if (n_integ < i_cfg.omin) begin
                n_integ = i_cfg.omin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_ma) * 64'(w_mb);
        if (i_cmd.load) begin
            r_err   <= w_err;
            r_errdz <= w_errdz;
            r_ofs   <= i_clamp_error_offset;
        end
        if (i_cmd.sum) begin
            r_up  <= w_frac;
            r_sum <= w_frac + r_integ + r_deriv;
        end
        if (i_cmd.clamp) begin
            r_outv   <= n_outv;
            r_sat    <= n_sat;
            r_saterr <= n_outv - r_sum + r_ofs;
        end
        if (i_cmd.diff) begin
            r_ti      <= w_frac;
            r_refresh <= w_refresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_deriv <= '0;
            r_filt  <= '0;
            r_prev  <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b1;
        end else begin
            if (i_cmd.restart) begin
                r_integ <= '0;
                r_pend  <= 1'b1;
            end
            if (i_cmd.clamp) begin
                r_filt <= (i_cfg.kf == '0) ? r_err : (r_filt + w_frac);
            end
            if (i_cmd.diff) begin
                if (w_refresh) begin
                    r_filt <= w_eff_f;
                    r_prev <= w_eff_f;
                    r_pend <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_cnt  <= w_cnt_inc[CNT_W-1:0];
                end
            end
            if (i_cmd.aw && r_refresh) begin
                r_deriv <= w_frac;
            end
            if (i_cmd.integ) begin
                r_integ <= n_integ;
            end
        end
    end

    assign o_control_out = r_outv;
    assign o_error_value = r_err;
    assign o_saturated   = r_sat;

endmodule

// ----- design/pid_deadzone_antiwindup.sv -----
// ----------------------------------------------------------------------------
// PID controller with dead zone and anti-windup
// Fixed-point PID step with derivative filter, decimated derivative and a
// back-calculation integrator, built as a sequencer around one multiplier.
// ----------------------------------------------------------------------------
// A compute item passes the step states (five products through one multiplier);
//   no new item is taken before its result enters the output register, and a
//   restart item leaves the controller idle.
// The output register lets the next item in while a result waits to be taken.
// Reset (synchronous, active low): gains, filter coefficient and dead zone to
//   zero, limits to the full signed range, loop state to zero, filter re-armed.
module pid_deadzone_antiwindup
    import pda_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int DIFF_DIVIDE   = DIFF_DIVIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input item channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_kind,
    input  logic signed [DATA_W-1:0] i_reference,
    input  logic signed [DATA_W-1:0] i_feedback,
    input  logic signed [DATA_W-1:0] i_clamp_error_offset,
    // Result item channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_control_out,
    output logic signed [DATA_W-1:0] o_error_value,
    output logic                     o_saturated,
    // Configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic        [IDX_W-1:0]  i_cfg_index,
    input  logic        [DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    logic w_slot_free;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_ctrl;
    logic signed [DATA_W-1:0] r_out_err;
    logic                     r_out_sat;

    logic signed [DATA_W-1:0] w_dp_ctrl;
    logic signed [DATA_W-1:0] w_dp_err;
    logic                     w_dp_sat;

    // Configuration writes are taken whenever out of reset; the dead zone
    // keeps 31 bits.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp   <= '0;
            r_cfg.ki   <= '0;
            r_cfg.kd   <= '0;
            r_cfg.kaw  <= '0;
            r_cfg.kf   <= '0;
            r_cfg.dz   <= '0;
            r_cfg.omax <= {1'b0, {(DATA_W-1){1'b1}}};
            r_cfg.omin <= {1'b1, {(DATA_W-1){1'b0}}};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KP:   r_cfg.kp   <= i_cfg_data;
                REG_KI:   r_cfg.ki   <= i_cfg_data;
                REG_KD:   r_cfg.kd   <= i_cfg_data;
                REG_KAW:  r_cfg.kaw  <= i_cfg_data;
                REG_KF:   r_cfg.kf   <= i_cfg_data;
                REG_DZ:   r_cfg.dz   <= i_cfg_data[DZ_W-1:0];
                REG_OMAX: r_cfg.omax <= i_cfg_data;
                REG_OMIN: r_cfg.omin <= i_cfg_data;
            endcase
        end
    end

    // The output slot frees up when empty or when its item is taken this cycle.
    assign w_slot_free = !r_out_valid || i_ready;

    pda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_slot_free (w_slot_free),
        .o_ready     (o_ready),
        .o_cmd       (w_cmd)
    );

    pda_dp #(
        .FRACTION_BITS (FRACTION_BITS),
        .DIFF_DIVIDE   (DIFF_DIVIDE)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_cfg                (r_cfg),
        .i_reference          (i_reference),
        .i_feedback           (i_feedback),
        .i_clamp_error_offset (i_clamp_error_offset),
        .o_control_out        (w_dp_ctrl),
        .o_error_value        (w_dp_err),
        .o_saturated          (w_dp_sat)
    );

    // Output register: load a finished item, drop valid once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_out_ctrl <= w_dp_ctrl;
            r_out_err  <= w_dp_err;
            r_out_sat  <= w_dp_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_control_out = r_out_ctrl;
    assign o_error_value = r_out_err;
    assign o_saturated   = r_out_sat;

endmodule

// ----- sim/pid_deadzone_antiwindup_test.sv -----
// ----------------------------------------------------------------------------
// PID step testbench
// Sends compute and restart items under random idling on both channels,
// predicts each result with a local fixed-point copy of the control step and
// checks every returned item field by field. Register settings change only
// between phases, once the block has gone idle.
// ----------------------------------------------------------------------------
module pid_deadzone_antiwindup_test;
    import pda_pkg::*;

    localparam int FRAC_BITS     = FRACTION_BITS_DEF;
    localparam int DECIMATE      = DIFF_DIVIDE_DEF;
    localparam int SETTLE_CYC    = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_REPORTS   = 10;
    localparam int RAND_PHASES   = 14;
    localparam int PHASE_ITEMS   = 130;
    localparam int TIMEOUT_UNITS = 10_000_000;

    localparam logic KIND_STEP    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [DATA_W-1:0] S32_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE_Q    = 32'h1 << FRAC_BITS;
    localparam logic [DATA_W-1:0] HALF_Q   = ONE_Q >> 1;
    localparam logic [DATA_W-1:0] QUART_Q  = ONE_Q >> 2;
    localparam logic [DATA_W-1:0] EIGHTH_Q = ONE_Q >> 3;

    // Drive every input to a known value from time zero
    logic                     i_clk                = 1'b0;
    logic                     i_rst_n              = 1'b0;
    logic                     i_valid              = 1'b0;
    logic                     o_ready;
    logic                     i_kind               = KIND_STEP;
    logic signed [DATA_W-1:0] i_reference          = '0;
    logic signed [DATA_W-1:0] i_feedback           = '0;
    logic signed [DATA_W-1:0] i_clamp_error_offset = '0;
    logic                     o_valid;
    logic                     i_ready              = 1'b0;
    logic signed [DATA_W-1:0] o_control_out;
    logic signed [DATA_W-1:0] o_error_value;
    logic                     o_saturated;
    logic                     i_cfg_valid          = 1'b0;
    logic                     o_cfg_ready;
    logic        [IDX_W-1:0]  i_cfg_index          = '0;
    logic        [DATA_W-1:0] i_cfg_data           = '0;

    pid_deadzone_antiwindup i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_kind               (i_kind),
        .i_reference          (i_reference),
        .i_feedback           (i_feedback),
        .i_clamp_error_offset (i_clamp_error_offset),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_control_out        (o_control_out),
        .o_error_value        (o_error_value),
        .o_saturated          (o_saturated),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    typedef struct {
        logic signed [DATA_W-1:0] control;
        logic signed [DATA_W-1:0] error;
        logic                     saturated;
    } t_pid_out;

    // Expected outputs, oldest first
    t_pid_out predicted_outputs[$];

    // Shadow of the register file and of the loop state
    t_cfg                     ctrl_regs;
    logic signed [DATA_W-1:0] integ_acc;
    logic signed [DATA_W-1:0] deriv_term;
    logic signed [DATA_W-1:0] filt_err;
    logic signed [DATA_W-1:0] prev_filt_err;
    logic        [CNT_W-1:0]  decim_cnt;
    logic                     filt_rearm;

    int  n_errors    = 0;
    int  n_steps     = 0;
    int  n_restarts  = 0;
    int  n_results   = 0;
    int  n_saturated = 0;
    int  n_settings  = 0;
    int  rx_stall    = 0;
    // Turn off idling on both channels for a whole phase
    bit  steady_flow = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void reset_pid_model();
        ctrl_regs      = '0;
        ctrl_regs.omax = S32_MAX;
        ctrl_regs.omin = S32_MIN;
        integ_acc      = '0;
        deriv_term     = '0;
        filt_err       = '0;
        prev_filt_err  = '0;
        decim_cnt      = '0;
        filt_rearm     = 1'b1;
    endfunction

    // Fractional multiply: full 64-bit product, arithmetic shift, keep 32 bits
    function automatic logic signed [DATA_W-1:0] q_mul(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] prod;
        wa   = a;
        wb   = b;
        prod = wa * wb;
        prod = prod >>> FRAC_BITS;
        return prod[DATA_W-1:0];
    endfunction

    // Advance the shadow loop by one accepted item; queue its result, if any
    function automatic void advance_pid(input logic                     kind,
                                        input logic signed [DATA_W-1:0] setpoint,
                                        input logic signed [DATA_W-1:0] measured,
                                        input logic signed [DATA_W-1:0] offset);
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] p_term;
        logic signed [DATA_W-1:0] total;
        logic signed [DATA_W-1:0] out_val;
        logic signed [DATA_W-1:0] sat_err;
        logic signed [DATA_W-1:0] delta;
        logic signed [63:0]       band;
        logic signed [63:0]       dz_w;
        logic                     clipped;
        t_pid_out                 res;

        if (kind == KIND_RESTART) begin
            integ_acc  = '0;
            filt_rearm = 1'b1;
            n_restarts++;
            return;
        end
        n_steps++;

        err  = setpoint - measured;
        band = err;
        dz_w = {33'b0, ctrl_regs.dz};
        // Shrink the error toward zero by the dead band, never past zero
        if (ctrl_regs.dz != '0) begin
            if (band > 0) begin
                band = band - dz_w;
                if (band < 0) band = 0;
            end
            if (band < 0) begin
                band = band + dz_w;
                if (band > 0) band = 0;
            end
        end

        p_term = q_mul(ctrl_regs.kp, band[DATA_W-1:0]);
        total  = p_term + integ_acc + deriv_term;

        // Upper limit wins when the limits are crossed
        clipped = 1'b1;
        if (total > $signed(ctrl_regs.omax)) begin
            out_val = ctrl_regs.omax;
        end else if (total < $signed(ctrl_regs.omin)) begin
            out_val = ctrl_regs.omin;
        end else begin
            out_val = total;
            clipped = 1'b0;
        end
        sat_err = out_val - total + offset;

        if (ctrl_regs.kf == '0) begin
            filt_err = err;
        end else begin
            delta    = err - filt_err;
            filt_err = filt_err + q_mul(ctrl_regs.kf, delta);
        end

        // Refresh the derivative once per decimation period
        if (decim_cnt + 1 >= DECIMATE) begin
            if (filt_rearm) begin
                filt_err      = err;
                prev_filt_err = err;
                filt_rearm    = 1'b0;
            end
            delta         = (filt_err - prev_filt_err) << DERIV_SHIFT;
            deriv_term    = q_mul(ctrl_regs.kd, delta);
            prev_filt_err = filt_err;
            decim_cnt     = '0;
        end else begin
            decim_cnt = decim_cnt + 1'b1;
        end

        if (ctrl_regs.ki != '0)
            integ_acc = integ_acc + q_mul(ctrl_regs.ki, p_term) + q_mul(ctrl_regs.kaw, sat_err);
        else
            integ_acc = '0;

        // Without back-calculation, hold the integrator inside the limits
        if (ctrl_regs.kaw == '0) begin
            if (integ_acc > $signed(ctrl_regs.omax))
                integ_acc = ctrl_regs.omax;
            else if (integ_acc < $signed(ctrl_regs.omin))
                integ_acc = ctrl_regs.omin;
        end

        res.control   = out_val;
        res.error     = err;
        res.saturated = clipped;
        predicted_outputs.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    function automatic void check_result();
        t_pid_out want;
        if (predicted_outputs.size() == 0) begin
            note_mismatch($sformatf("unexpected item: control %0d error %0d saturated %0b",
                                    o_control_out, o_error_value, o_saturated));
            return;
        end
        want = predicted_outputs.pop_front();
        n_results++;
        if (o_saturated) n_saturated++;
        if (o_control_out !== want.control)
            note_mismatch($sformatf("item %0d control_out: expected %0d, got %0d",
                                    n_results, want.control, o_control_out));
        if (o_error_value !== want.error)
            note_mismatch($sformatf("item %0d error_value: expected %0d, got %0d",
                                    n_results, want.error, o_error_value));
        if (o_saturated !== want.saturated)
            note_mismatch($sformatf("item %0d saturated: expected %0b, got %0b",
                                    n_results, want.saturated, o_saturated));
    endfunction

    // Idle lengths: mostly none or short, now and then long
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Take results and stall the result channel at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_result();
        if (rx_stall > 0) begin
            i_ready <= 1'b0;
            rx_stall--;
        end else begin
            i_ready  <= 1'b1;
            rx_stall = next_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Hold the item until accepted; leave valid high for a back-to-back item
    task automatic send_item(input logic                     kind,
                             input logic signed [DATA_W-1:0] setpoint,
                             input logic signed [DATA_W-1:0] measured,
                             input logic signed [DATA_W-1:0] offset);
        i_valid              <= 1'b1;
        i_kind               <= kind;
        i_reference          <= setpoint;
        i_feedback           <= measured;
        i_clamp_error_offset <= offset;
        do @(posedge i_clk); while (!o_ready);
        advance_pid(kind, setpoint, measured, offset);
    endtask

    task automatic pause_input(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every expected item, then let the sequencer settle
    task automatic wait_idle();
        int waited;
        waited  = 0;
        i_valid <= 1'b0;
        while (predicted_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_KP:   ctrl_regs.kp   = value;
            REG_KI:   ctrl_regs.ki   = value;
            REG_KD:   ctrl_regs.kd   = value;
            REG_KAW:  ctrl_regs.kaw  = value;
            REG_KF:   ctrl_regs.kf   = value;
            REG_DZ:   ctrl_regs.dz   = value[DZ_W-1:0];
            REG_OMAX: ctrl_regs.omax = value;
            REG_OMIN: ctrl_regs.omin = value;
        endcase
    endtask

    // Rewrite the whole register file while the block is idle
    task automatic program_regs(input logic [DATA_W-1:0] kp,   input logic [DATA_W-1:0] ki,
                                input logic [DATA_W-1:0] kd,   input logic [DATA_W-1:0] kaw,
                                input logic [DATA_W-1:0] kf,   input logic [DATA_W-1:0] dz,
                                input logic [DATA_W-1:0] omax, input logic [DATA_W-1:0] omin);
        wait_idle();
        write_reg(REG_KP,   kp);
        write_reg(REG_KI,   ki);
        write_reg(REG_KD,   kd);
        write_reg(REG_KAW,  kaw);
        write_reg(REG_KF,   kf);
        write_reg(REG_DZ,   dz);
        write_reg(REG_OMAX, omax);
        write_reg(REG_OMIN, omin);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Mix of small fixed-point values, full-range words and corner words
    function automatic logic [DATA_W-1:0] pick_word(input int span_bits);
        logic [DATA_W-1:0] raw;
        int                r;
        raw = $urandom;
        r   = $urandom_range(0, 9);
        if (r < 5) return $signed(raw) >>> (31 - span_bits);
        if (r < 8) return raw;
        case ($urandom_range(0, 5))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2:       return '0;
            3:       return '1;
            4:       return ONE_Q;
            default: return -ONE_Q;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] maybe_zero(input int pct, input int span_bits);
        if ($urandom_range(0, 99) < pct) return '0;
        return pick_word(span_bits);
    endfunction

    task automatic random_item();
        logic                     kind;
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measured;
        logic signed [DATA_W-1:0] edge_err;
        kind     = ($urandom_range(0, 99) < 4) ? KIND_RESTART : KIND_STEP;
        setpoint = pick_word(26);
        // Aim a share of the errors right at the dead-band edge
        if ($urandom_range(0, 99) < 30) begin
            edge_err = {1'b0, ctrl_regs.dz} + $urandom_range(0, 8) - 4;
            if ($urandom_range(0, 1)) edge_err = -edge_err;
            measured = setpoint - edge_err;
        end else begin
            measured = pick_word(26);
        end
        send_item(kind, setpoint, measured, pick_word(24));
    endtask

    task automatic random_settings(input int phase);
        logic [DATA_W-1:0] lim_a;
        logic [DATA_W-1:0] lim_b;
        logic [DATA_W-1:0] omax;
        logic [DATA_W-1:0] omin;
        logic [DATA_W-1:0] dz;
        logic [DATA_W-1:0] kf;
        int                r;
        lim_a = $urandom_range(0, 1 << 28);
        lim_b = $urandom_range(0, 1 << 28);
        r     = $urandom_range(0, 9);
        if (r < 7) begin
            omax = lim_a;
            omin = -lim_b;
        end else if (r < 8) begin
            omax = S32_MAX;
            omin = S32_MIN;
        end else if (r < 9) begin
            omax = pick_word(30);
            omin = pick_word(30);
        end else begin
            omax = -lim_b;
            omin = lim_a;
        end
        r = $urandom_range(0, 9);
        // Keep the top bit random too: the block must drop it
        if (r < 4)      dz = '0;
        else if (r < 8) dz = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 20))};
        else            dz = $urandom;
        kf = ($urandom_range(0, 99) < 30) ? '0 :
             ($urandom_range(0, 99) < 80) ? 32'($urandom_range(0, ONE_Q)) : pick_word(30);
        case (phase)
            0: program_regs(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                            S32_MAX, S32_MAX);
            1: program_regs(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, '0,
                            S32_MIN, S32_MIN);
            default: program_regs(pick_word(26), maybe_zero(20, 22), maybe_zero(25, 24),
                                  maybe_zero(30, 22), kf, dz, omax, omin);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset settings: zero gains, so only the wrapped error shows
    task automatic test_reset_state();
        send_item(KIND_STEP, S32_MAX, S32_MIN, S32_MAX);
        send_item(KIND_STEP, S32_MIN, S32_MAX, S32_MIN);
        send_item(KIND_STEP, '0, '0, '0);
    endtask

    // Unity gain; dead band written with the top data bit set
    task automatic test_dead_zone();
        program_regs(ONE_Q, '0, '0, '0, '0, 32'h8000_03E8, S32_MAX, S32_MIN);
        send_item(KIND_STEP, 32'sd1000, '0, '0);
        send_item(KIND_STEP, 32'sd1001, '0, '0);
        send_item(KIND_STEP, -32'sd1001, '0, '0);
        send_item(KIND_STEP, S32_MAX, S32_MIN, '0);
    endtask

    // Clamp both ways with back-calculation, then with crossed limits
    task automatic test_output_limits();
        program_regs(ONE_Q, QUART_Q, '0, EIGHTH_Q, '0, '0, 32'sd5000, -32'sd5000);
        send_item(KIND_STEP, 32'sd10000, '0, S32_MAX);
        send_item(KIND_STEP, -32'sd10000, '0, S32_MIN);
        program_regs(ONE_Q, '0, '0, '0, '0, '0, -32'sd100, 32'sd100);
        send_item(KIND_STEP, '0, '0, '0);
        send_item(KIND_STEP, -32'sd1000, '0, '0);
    endtask

    // Integrator in plain-clamp mode (no back-calculation), then a restart clears it
    task automatic test_integrator();
        program_regs(ONE_Q, HALF_Q, '0, '0, '0, '0, 32'sd20000, -32'sd20000);
        send_item(KIND_STEP, 32'sd15000, '0, '0);
        send_item(KIND_STEP, 32'sd15000, '0, '0);
        send_item(KIND_RESTART, S32_MAX, S32_MIN, S32_MAX);
        send_item(KIND_STEP, -32'sd15000, '0, S32_MIN);
    endtask

    // Ramp the error across two decimation periods, restart, step again
    task automatic test_derivative();
        program_regs('0, '0, ONE_Q, '0, QUART_Q, '0, S32_MAX, S32_MIN);
        for (int k = 1; k <= 9; k++)
            send_item(KIND_STEP, 32'(k * 1000), '0, '0);
        send_item(KIND_RESTART, '0, '0, '0);
        send_item(KIND_STEP, 32'sd50000, '0, '0);
    endtask

    // Random settings per phase, the extremes first, random items within
    task automatic test_random_regimes();
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            random_settings(phase);
            steady_flow = (phase % 4 == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_item();
                pause_input(next_gap());
            end
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_pid_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_dead_zone();
        test_output_limits();
        test_integrator();
        test_derivative();
        test_random_regimes();

        wait_idle();
        if (predicted_outputs.size() != 0) begin
            n_errors += predicted_outputs.size() - 1;
            note_mismatch($sformatf("%0d expected items never arrived",
                                    predicted_outputs.size()));
        end

        $display("covered %0d steps and %0d restarts over %0d register settings",
                 n_steps, n_restarts, n_settings);
        $display("checked %0d results, %0d of them clamped; %0d mismatches",
                 n_results, n_saturated, n_errors);
        if (n_errors == 0)
            $display("pid_deadzone_antiwindup_test: done, clean");
        else
            $display("pid_deadzone_antiwindup_test: done, errors");
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_UNITS);
        $display("pid_deadzone_antiwindup_test: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
design/pda_pkg.sv
design/pda_ctrl.sv
design/pda_dp.sv
design/pid_deadzone_antiwindup.sv
sim/pid_deadzone_antiwindup_test.sv
